// ===== design/adam_pu_pkg.sv =====
// Shared constants for the Adam bias update block: register indexes,
// reset values and fixed-point constants. Depends on nothing.
package adam_pu_pkg;

  localparam int IDX_W      = 10;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_USE_ADAM      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_FIRST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_SECOND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE    = 3'd4;

  // Register values after reset.
  localparam logic        RST_USE_ADAM      = 1'b1;
  localparam logic [15:0] RST_BETA_FIRST    = 16'd58982;
  localparam logic [15:0] RST_BETA_SECOND   = 16'd65470;
  localparam logic [23:0] RST_LEARNING_RATE = 24'd16777;
  localparam logic [15:0] RST_BATCH_SIZE    = 16'd32;

  // Epsilon of 1e-7 rounded to Q8.24.
  localparam logic [32:0] EPS_Q = 33'd2;

endpackage

// ===== design/adam_parameter_update.sv =====
// Adam optimizer step (or a plain gradient step) for a bias vector, without bias correction.
// Depends on adam_pu_pkg for register indexes and constants.
//
//  channel | signals                                        | direction
//  in      | in_valid_i/in_ready_o, element_index_i,        | into block
//          | gradient_sum_i, weight_in_i                    |
//  out     | out_valid_o/out_ready_i, weight_out_o,         | out of block
//          | out_index_o, saturated_o                       |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | into block
//
// From acceptance to the result a word passes the batch division and then, in Adam
// mode, the store index division (only when NUM_ELEMENTS is below 1024), the moment
// steps, the square root and the final division; in plain mode a multiply follows.
// The divider is shared and restoring (one quotient bit per cycle, used for the batch
// division, the store index and the final step); the square root takes two radicand
// bits per cycle. The next word is accepted in the cycle after the result is loaded.
// The last step holds while the previous result still waits in the output register.
// After reset the moment stores are cleared one entry a cycle; no word is accepted
// meanwhile, configuration is.
module adam_parameter_update
  import adam_pu_pkg::*;
#(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [IDX_W-1:0]      element_index_i,
  input  logic signed [VAL_W-1:0] gradient_sum_i,
  input  logic signed [VAL_W-1:0] weight_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [VAL_W-1:0] weight_out_o,
  output logic [IDX_W-1:0]      out_index_o,
  output logic                  saturated_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SLOT_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam bit SLOT_DIRECT = (NUM_ELEMENTS >= 1024);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_ELEMENTS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVG = 4'd1;
  localparam logic [3:0] S_DIVS = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_M4   = 4'd7;
  localparam logic [3:0] S_M5   = 4'd8;
  localparam logic [3:0] S_M6   = 4'd9;
  localparam logic [3:0] S_SQRT = 4'd10;
  localparam logic [3:0] S_DIVQ = 4'd11;
  localparam logic [3:0] S_PMUL = 4'd12;
  localparam logic [3:0] S_PFIN = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic        use_adam_q;
  logic [15:0] beta_first_q, beta_second_q, batch_size_q;
  logic [23:0] learning_rate_q;

  // Control.
  logic              clr_busy_q;
  logic [SLOT_W-1:0] clr_cnt_q;
  logic              out_valid_q;
  logic              in_acc, out_load;
  logic [5:0]        cnt_q;

  // Word registers.
  logic [IDX_W-1:0]  idx_q;
  logic [VAL_W-1:0]  w_q;
  logic              gneg_q;
  logic [31:0]       gmag_q;
  logic [SLOT_W-1:0] slot_q;
  logic [31:0]       g2_q;
  logic [31:0]       v_q, s_q;
  logic              sat_q;
  logic [55:0]       q_q;
  logic [31:0]       gabs;
  logic [15:0]       bs_eff;

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q, acc_q, mix_sum;
  logic               mul_en;
  logic [31:0]        vmag;

  // Shared divider.
  logic [31:0] dv_rem_q, dv_rem_d, dv_dvs_q;
  logic [55:0] dv_quo_q, dv_quo_d;
  logic [32:0] dv_sh;
  logic [33:0] dv_diff;

  // Square root.
  logic [57:0] sq_x_q;
  logic [31:0] sq_r_q, sq_r_d;
  logic [29:0] sq_root_q, sq_root_d;
  logic [33:0] sq_sh, sq_t, sq_diff;
  logic [32:0] s_eps;

  // Moment stores.
  logic [31:0]       mem_v [NUM_ELEMENTS];
  logic [31:0]       mem_s [NUM_ELEMENTS];
  logic [31:0]       rd_v_q, rd_s_q;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;

  // Final sum.
  logic signed [57:0] res;
  logic               res_ovf;
  logic [31:0]        res_clip;

  assign in_ready_o  = (state_q == S_IDLE) && !clr_busy_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

  assign gabs   = gradient_sum_i[31] ? (~gradient_sum_i + 32'd1) : gradient_sum_i;
  assign bs_eff = (batch_size_q == 16'd0) ? 16'd1 : batch_size_q;
  assign vmag   = v_q[31] ? (~v_q + 32'd1) : v_q;

  // Divider step: one quotient bit per cycle.
  always_comb begin
    dv_sh    = {dv_rem_q, dv_quo_q[55]};
    dv_diff  = {1'b0, dv_sh} - {2'b00, dv_dvs_q};
    dv_rem_d = dv_diff[33] ? dv_sh[31:0] : dv_diff[31:0];
    dv_quo_d = {dv_quo_q[54:0], ~dv_diff[33]};
  end

  // Square root step: two radicand bits per cycle.
  always_comb begin
    sq_sh     = {sq_r_q, sq_x_q[57:56]};
    sq_t      = {2'b00, sq_root_q, 2'b01};
    sq_diff   = sq_sh - sq_t;
    sq_r_d    = sq_diff[33] ? sq_sh[31:0] : sq_diff[31:0];
    sq_root_d = {sq_root_q[28:0], ~sq_diff[33]};
  end

  assign s_eps = {1'b0, s_q} + EPS_Q;

  // Multiplier operand selection.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state_q)
      S_RD: begin
        mul_a = {1'b0, gmag_q};
        mul_b = {1'b0, gmag_q};
      end
      S_M1: begin
        mul_a = {17'd0, beta_first_q};
        mul_b = {rd_v_q[31], rd_v_q};
      end
      S_M2: begin
        mul_a = 33'(17'h10000 - {1'b0, beta_first_q});
        mul_b = gneg_q ? -$signed({1'b0, gmag_q}) : $signed({1'b0, gmag_q});
      end
      S_M3: begin
        mul_a = {17'd0, beta_second_q};
        mul_b = {1'b0, rd_s_q};
      end
      S_M4: begin
        mul_a = 33'(17'h10000 - {1'b0, beta_second_q});
        mul_b = {1'b0, g2_q};
      end
      S_M5: begin
        mul_a = {9'd0, learning_rate_q};
        mul_b = {1'b0, vmag};
      end
      S_PMUL: begin
        mul_a = {9'd0, learning_rate_q};
        mul_b = {1'b0, gmag_q};
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mix_sum = acc_q + prod_q;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_DIVG;
      S_DIVG: begin
        if (cnt_q == 6'd0) begin
          if (!use_adam_q)     state_d = S_PMUL;
          else if (SLOT_DIRECT) state_d = S_RD;
          else                 state_d = S_DIVS;
        end
      end
      S_DIVS: if (cnt_q == 6'd0) state_d = S_RD;
      S_RD:   state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_M4;
      S_M4:   state_d = S_M5;
      S_M5:   state_d = S_M6;
      S_M6:   state_d = S_SQRT;
      S_SQRT: if (cnt_q == 6'd0) state_d = S_DIVQ;
      S_DIVQ: if (cnt_q == 6'd0) state_d = S_FIN;
      S_PMUL: state_d = S_PFIN;
      S_PFIN: state_d = S_FIN;
      S_FIN:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers, configuration and clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      clr_busy_q      <= 1'b1;
      clr_cnt_q       <= '0;
      out_valid_q     <= 1'b0;
      use_adam_q      <= RST_USE_ADAM;
      beta_first_q    <= RST_BETA_FIRST;
      beta_second_q   <= RST_BETA_SECOND;
      learning_rate_q <= RST_LEARNING_RATE;
      batch_size_q    <= RST_BATCH_SIZE;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
        if (clr_cnt_q == SLOT_LAST) clr_busy_q <= 1'b0;
      end
      if (out_load)                       out_valid_q <= 1'b1;
      else if (out_ready_i)               out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_USE_ADAM:      use_adam_q      <= cfg_data_i[0];
          REG_BETA_FIRST:    beta_first_q    <= cfg_data_i[15:0];
          REG_BETA_SECOND:   beta_second_q   <= cfg_data_i[15:0];
          REG_LEARNING_RATE: learning_rate_q <= cfg_data_i;
          REG_BATCH_SIZE:    batch_size_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_q    <= element_index_i;
          w_q      <= weight_in_i;
          gneg_q   <= gradient_sum_i[31];
          sat_q    <= 1'b0;
          dv_rem_q <= '0;
          dv_quo_q <= {gabs, 24'd0};
          dv_dvs_q <= 32'(bs_eff);
          cnt_q    <= 6'd31;
        end
      end
      S_DIVG: begin
        if (cnt_q == 6'd0) begin
          gmag_q   <= dv_quo_d[31:0];
          slot_q   <= SLOT_W'(idx_q);
          dv_rem_q <= '0;
          dv_quo_q <= {idx_q, 46'd0};
          dv_dvs_q <= 32'(NUM_ELEMENTS);
          cnt_q    <= 6'd9;
        end else begin
          dv_rem_q <= dv_rem_d;
          dv_quo_q <= dv_quo_d;
          cnt_q    <= cnt_q - 6'd1;
        end
      end
      S_DIVS: begin
        dv_rem_q <= dv_rem_d;
        dv_quo_q <= dv_quo_d;
        cnt_q    <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) slot_q <= dv_rem_d[SLOT_W-1:0];
      end
      S_M1: begin
        // g squared in Q8.24, clipped to the unsigned 32-bit range.
        if (|prod_q[63:56]) begin
          g2_q  <= '1;
          sat_q <= 1'b1;
        end else begin
          g2_q <= prod_q[55:24];
        end
      end
      S_M2: acc_q <= prod_q;
      S_M3: v_q   <= mix_sum[47:16];
      S_M4: acc_q <= prod_q;
      S_M5: s_q   <= mix_sum[47:16];
      S_M6: begin
        sq_x_q    <= {1'b0, s_eps, 24'd0};
        sq_r_q    <= '0;
        sq_root_q <= '0;
        cnt_q     <= 6'd28;
      end
      S_SQRT: begin
        sq_x_q    <= {sq_x_q[55:0], 2'b00};
        sq_r_q    <= sq_r_d;
        sq_root_q <= sq_root_d;
        if (cnt_q == 6'd0) begin
          dv_rem_q <= '0;
          dv_quo_q <= prod_q[55:0];
          dv_dvs_q <= 32'(sq_root_d);
          cnt_q    <= 6'd55;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
      S_DIVQ: begin
        dv_rem_q <= dv_rem_d;
        dv_quo_q <= dv_quo_d;
        cnt_q    <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) q_q <= dv_quo_d;
      end
      S_PFIN: q_q <= 56'(prod_q[55:24]);
      default: ;
    endcase
  end

  // Moment stores: clearing pass after reset, one write per Adam-mode update.
  assign wr_en   = clr_busy_q || (state_q == S_M6);
  assign wr_addr = clr_busy_q ? clr_cnt_q : slot_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_v[wr_addr] <= clr_busy_q ? 32'd0 : v_q;
      mem_s[wr_addr] <= clr_busy_q ? 32'd0 : s_q;
    end
    if (state_q == S_RD) begin
      rd_v_q <= mem_v[slot_q];
      rd_s_q <= mem_s[slot_q];
    end
  end

  // Weight update with signed 32-bit clipping.
  always_comb begin
    if (use_adam_q ? v_q[31] : gneg_q)
      res = $signed({{26{w_q[31]}}, w_q}) + $signed({2'b00, q_q});
    else
      res = $signed({{26{w_q[31]}}, w_q}) - $signed({2'b00, q_q});
    res_ovf  = !((&res[57:31]) || !(|res[57:31]));
    res_clip = res[57] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      weight_out_o <= res_ovf ? res_clip : res[31:0];
      out_index_o  <= idx_q;
      saturated_o  <= sat_q || res_ovf;
    end
  end

  // The clearing pass runs only while the sequencer is idle.
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (state_q == S_IDLE))
    else $error("moment store clear overlaps an update");

  // A word is never accepted while one is still being worked on.
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input ready while sequencer busy");

  // The square root never yields a divisor below sqrt(eps).
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT && cnt_q == 6'd0) |=> (dv_dvs_q >= 32'd5792))
    else $error("square root below epsilon floor");

  // A result enters the output register only as the sequencer leaves its last step.
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == S_IDLE) && out_valid_q)
    else $error("result load without return to idle");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the Adam bias update block: directed and random words, checked
// against a fixed-point model of the update. Depends on adam_pu_pkg and the RTL.
module tb_top;
  import adam_pu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ELEMENTS = 1024;
  localparam int CYCLE_LIMIT  = 1500000;

  typedef struct packed {
    logic signed [31:0] weight;
    logic [9:0]         index;
    logic               sat;
  } update_t;

  // Expected-update store with its own copy of the moments and registers.
  class update_scoreboard;
    logic signed [31:0] first_mom [NUM_ELEMENTS];
    logic [31:0]        second_mom [NUM_ELEMENTS];
    bit          adam_on = RST_USE_ADAM;
    logic [15:0] b1 = RST_BETA_FIRST;
    logic [15:0] b2 = RST_BETA_SECOND;
    logic [23:0] rate = RST_LEARNING_RATE;
    logic [15:0] batch = RST_BATCH_SIZE;
    update_t     pending[$];
    int          errors;
    int          checked;

    function new();
      foreach (first_mom[i]) begin
        first_mom[i] = '0;
        second_mom[i] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_USE_ADAM:      adam_on = val[0];
        REG_BETA_FIRST:    b1 = val[15:0];
        REG_BETA_SECOND:   b2 = val[15:0];
        REG_LEARNING_RATE: rate = val[23:0];
        REG_BATCH_SIZE:    batch = val[15:0];
        default: ;
      endcase
    endfunction

    static function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Work out the updated weight for one accepted word.
    function void note_word(logic [9:0] idx, logic signed [31:0] gsum,
                            logic signed [31:0] w);
      longint          g, v, res, mix;
      longint unsigned gmag, bs, g2, s, d, vmag, qmag;
      bit              gneg, qneg, sat;
      int              slot;
      update_t         e;
      slot = idx % NUM_ELEMENTS;
      bs = (batch == 0) ? 1 : batch;
      gneg = gsum < 0;
      gmag = gneg ? -longint'(gsum) : longint'(gsum);
      gmag = gmag / bs;
      g = gneg ? -longint'(gmag) : longint'(gmag);
      sat = 0;
      if (adam_on) begin
        g2 = (gmag * gmag) >> 24;
        if (g2 > 64'hFFFF_FFFF) begin
          g2 = 64'hFFFF_FFFF;
          sat = 1;
        end
        // Arithmetic shift floors toward minus infinity.
        mix = longint'(b1) * longint'(first_mom[slot]) + (65536 - longint'(b1)) * g;
        v = mix >>> 16;
        s = (longint'(b2) * longint'(second_mom[slot])
             + (65536 - longint'(b2)) * g2) >> 16;
        first_mom[slot] = v[31:0];
        second_mom[slot] = s[31:0];
        d = int_sqrt((s + 2) << 24);
        qneg = v < 0;
        vmag = qneg ? -v : v;
        qmag = (longint'(rate) * vmag) / d;
      end else begin
        qneg = gneg;
        qmag = (longint'(rate) * gmag) >> 24;
      end
      res = qneg ? longint'(w) + longint'(qmag) : longint'(w) - longint'(qmag);
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647;
        sat = 1;
      end else if (res < -64'sd2147483648) begin
        res = -64'sd2147483648;
        sat = 1;
      end
      e.weight = res[31:0];
      e.index = idx;
      e.sat = sat;
      pending.push_back(e);
    endfunction

    function void check_update(update_t got);
      update_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected update, actual %h/%0d/%0b", $time,
                 got.weight, got.index, got.sat);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.weight !== e.weight) begin
        $display("%0t: weight expected %h actual %h", $time, e.weight, got.weight);
        errors++;
      end
      if (got.index !== e.index) begin
        $display("%0t: index expected %0d actual %0d", $time, e.index, got.index);
        errors++;
      end
      if (got.sat !== e.sat) begin
        $display("%0t: saturated expected %0b actual %0b", $time, e.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_ready_o;
  logic [IDX_W-1:0] element_index_i = '0;
  logic signed [VAL_W-1:0] gradient_sum_i = '0, weight_in_i = '0;
  logic out_valid_o, out_ready_i = 0;
  logic signed [VAL_W-1:0] weight_out_o;
  logic [IDX_W-1:0] out_index_o;
  logic saturated_o;
  logic cfg_valid_i = 0, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  update_scoreboard sb = new();
  int cycles;
  int words_sent;
  bit stall_on = 1;

  adam_parameter_update #(.NUM_ELEMENTS(NUM_ELEMENTS)) dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: stalls in runs, with stall-free stretches.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_update('{weight_out_o, out_index_o, saturated_o});
    if ($urandom_range(0, 40) == 0) stall_on <= !stall_on;
    out_ready_i <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    cfg_valid_i <= 0;
  endtask

  // Send one word; valid stays up if another follows directly.
  task automatic send_word(logic [9:0] idx, logic signed [31:0] g,
                           logic signed [31:0] w, bit keep);
    in_valid_i <= 1;
    element_index_i <= idx;
    gradient_sum_i <= g;
    weight_in_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(idx, g, w);
    words_sent++;
    if (!keep) in_valid_i <= 0;
  endtask

  // Wait until every update has come back, then let the block settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFF0 : 32'sh8000_0010;
      default: return $signed($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  // Random phase: bursts with gaps; indexes mostly from a small set so
  // moments accumulate over several steps.
  task automatic random_phase(int n);
    int burst;
    logic [9:0] idx;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n > 0; k++) begin
        idx = $urandom_range(0, 3) != 0 ? 10'($urandom_range(0, 15)) : 10'($urandom);
        n--;
        send_word(idx, rand_val(), rand_val(), k + 1 < burst && n > 0);
      end
      repeat ($urandom_range(0, 200)) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;

    // Directed words at reset settings: extremes, both signs, top index.
    send_word(10'd0, 32'sh7FFF_FFFF, 32'sh0, 0);
    send_word(10'd1023, 32'sh8000_0000, 32'sh7FFF_FFFF, 1);
    send_word(10'd0, 32'sh8000_0000, 32'sh8000_0000, 1);
    send_word(10'd5, 32'sh0, 32'sh7FFF_FFFF, 1);
    send_word(10'd5, -32'sd1, -32'sd1, 0);
    drain();

    // Zero batch, extreme betas and rate.
    write_reg(REG_BATCH_SIZE, 24'd0);
    write_reg(REG_BETA_FIRST, 24'd0);
    write_reg(REG_BETA_SECOND, 24'd0);
    write_reg(REG_LEARNING_RATE, 24'hFFFFFF);
    send_word(10'd7, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_word(10'd7, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_word(10'd8, 32'sh0000_1000, 32'sh0, 0);
    drain();
    write_reg(REG_BETA_FIRST, 24'hFFFF);
    write_reg(REG_BETA_SECOND, 24'hFFFF);
    write_reg(REG_BATCH_SIZE, 24'hFFFF);
    send_word(10'd7, 32'sh7FFF_FFFF, 32'sh0, 0);
    send_word(10'd9, 32'sh8000_0000, 32'sh0, 0);
    drain();

    // Plain mode, rate extremes.
    write_reg(REG_USE_ADAM, 24'd0);
    write_reg(REG_BATCH_SIZE, 24'd1);
    send_word(10'd3, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_word(10'd3, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    drain();
    write_reg(REG_LEARNING_RATE, 24'd0);
    send_word(10'd3, 32'sh1234_5678, 32'sh0, 0);
    drain();

    // Random phases over several settings.
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_USE_ADAM, 24'(p != 2 && p != 5));
      write_reg(REG_BETA_FIRST, 24'($urandom_range(0, 65535)));
      write_reg(REG_BETA_SECOND, 24'($urandom_range(0, 65535)));
      write_reg(REG_LEARNING_RATE, 24'($urandom));
      write_reg(REG_BATCH_SIZE, 24'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                           : $urandom_range(1, 64)));
      random_phase(190);
      drain();
    end

    $display("Sent %0d words over directed, plain and Adam phases; %0d updates checked.",
             words_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/adam_pu_pkg.sv
design/adam_parameter_update.sv
sim/tb_top.sv
